[src/scc_pkg.sv]
// Shared types and codes for the strongly connected components core.
package scc_pkg;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam int unsigned FIELD_W = 11;

  typedef struct packed {
    action_e             action;
    logic [FIELD_W-1:0]  from_node;
    logic [FIELD_W-1:0]  to_node;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [FIELD_W-1:0]  component_count;
    logic [FIELD_W-1:0]  node_label;
    logic [FIELD_W-1:0]  label_size;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ROOT,
    ST_ROOT_W,
    ST_STEP,
    ST_EDGE_W,
    ST_VIS_W,
    ST_POP,
    ST_POP_W,
    ST_PARENT,
    ST_PAR_W,
    ST_ADD_W,
    ST_QRY_W,
    ST_QSZ_W
  } state_e;

endpackage

[src/strongly_connected_components_core.sv]
// Top level: command handshake, node_count register on APB, search engine.
//
//   channel  | signals                                      | beat taken when
//   ---------+----------------------------------------------+------------------------
//   command  | start_i, busy_o, action_i, from_node_i, ...  | start_i && !busy_o
//   result   | done_o, status_o, component_count_o, ...     | done_o (one cycle)
//   config   | psel, penable, pwrite, paddr, pwdata, prdata | psel && penable && pwrite
//
// Add: head read, then edge write; a rejected add answers from idle.
// Query: label read, then size read if labelled. Clear: sweep of all MAX_NODES slots.
// Run: sweep, root checks, edge steps, member pops, returns; memory reads pace each.
// After reset a clearing pass runs with busy_o high.
// The result is a one-cycle strobe; the receiver cannot stall it.
module strongly_connected_components_core #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [10:0] from_node_i,
  input  logic [10:0] to_node_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [10:0] component_count_o,
  output logic [10:0] node_label_o,
  output logic [10:0] label_size_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scc_pkg::*;

  localparam int unsigned OW = $clog2(MAX_NODES + 1);

  logic [10:0]   node_count_q;
  logic [31:0]   n32;
  logic [OW-1:0] active_n;
  cmd_t          cmd;
  res_t          res;
  logic          busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 11'd1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      node_count_q <= pwdata[10:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {21'd0, node_count_q};
  assign pready = 1'b1;

  assign n32      = (32'(node_count_q) > MAX_NODES) ? MAX_NODES : 32'(node_count_q);
  assign active_n = n32[OW-1:0];

  assign cmd.action    = action_e'(action_i);
  assign cmd.from_node = from_node_i;
  assign cmd.to_node   = to_node_i;

  scc_engine #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .cmd_valid_i(start_i && !busy),
    .cmd_i      (cmd),
    .active_n_i (active_n),
    .busy_o     (busy),
    .res_valid_o(done_o),
    .res_o      (res)
  );

  assign busy_o            = busy;
  assign status_o          = res.status;
  assign component_count_o = res.component_count;
  assign node_label_o      = res.node_label;
  assign label_size_o      = res.label_size;

endmodule

[src/scc_ram.sv]
// Generic simple dual-port RAM with registered read.
module scc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/scc_engine.sv]
// Command sequencer: edge loading, Tarjan search over memories, queries and clears.
module scc_engine #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096,
  localparam int unsigned NW  = $clog2(MAX_NODES),
  localparam int unsigned OW  = $clog2(MAX_NODES + 1),
  localparam int unsigned EAW = $clog2(MAX_EDGES),
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  scc_pkg::cmd_t cmd_i,
  input  logic [OW-1:0] active_n_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output scc_pkg::res_t res_o
);
  import scc_pkg::*;

  localparam int unsigned CFW = NW + EW + 2 * OW;
  localparam logic [EW-1:0] NULL_LINK = EW'(MAX_EDGES);

  // memory ports
  logic           tgt_we, lnk_we, head_we, vis_we, onk_we, lab_we, siz_we, mem_we, call_we;
  logic [EAW-1:0] tgt_waddr, edge_raddr;
  logic [NW-1:0]  tgt_wdata, tgt_rdata;
  logic [EW-1:0]  lnk_wdata, lnk_rdata, head_wdata, head_rdata;
  logic [NW-1:0]  head_waddr, head_raddr, node_waddr, node_raddr;
  logic [OW-1:0]  vis_wdata, vis_rdata, lab_wdata, lab_rdata, siz_wdata, siz_rdata;
  logic           onk_wdata, onk_rdata;
  logic [NW-1:0]  lab_waddr, lab_raddr, siz_waddr, siz_raddr, onk_waddr;
  logic [NW-1:0]  mem_waddr, mem_raddr, mem_wdata, mem_rdata;
  logic [NW-1:0]  call_waddr, call_raddr;
  logic [CFW-1:0] call_wdata, call_rdata;

  state_e         state_q, state_d;
  logic [OW-1:0]  sweep_q, sweep_d;
  logic           sw_head_q, sw_head_d, sw_run_q, sw_run_d, sw_resp_q, sw_resp_d;
  logic [OW-1:0]  root_q, root_d, cdepth_q, cdepth_d, mdepth_q, mdepth_d;
  logic [OW-1:0]  ord_q, ord_d, comp_q, comp_d, label_q, label_d, pcnt_q, pcnt_d;
  logic [EW-1:0]  total_q, total_d;
  logic [NW-1:0]  top_v_q, top_v_d, w_q, w_d, u_q, u_d, t_q, t_d;
  logic [EW-1:0]  top_e_q, top_e_d;
  logic [OW-1:0]  top_low_q, top_low_d, top_vis_q, top_vis_d;
  logic           res_valid_d, res_valid_q;
  res_t           res_d, res_q;

  logic [31:0]    from_m1, to_m1, n32, comp_ext, lab_ext, siz_ext;
  logic           from_bad, to_bad;
  logic [OW-1:0]  ord_p1, cdepth_m1, mdepth_m1, label_m1, lab_m1;
  logic           do_enter;
  logic [NW-1:0]  enter_node;
  logic [EW-1:0]  enter_head;
  logic           resp;
  logic [1:0]     resp_status;
  logic [OW-1:0]  resp_label, resp_size;

  assign n32      = 32'(active_n_i);
  assign from_m1  = 32'(cmd_i.from_node) - 32'd1;
  assign to_m1    = 32'(cmd_i.to_node) - 32'd1;
  assign from_bad = (cmd_i.from_node == '0) || (32'(cmd_i.from_node) > n32);
  assign to_bad   = (cmd_i.to_node == '0) || (32'(cmd_i.to_node) > n32);
  assign ord_p1    = ord_q + OW'(1);
  assign cdepth_m1 = cdepth_q - OW'(1);
  assign mdepth_m1 = mdepth_q - OW'(1);
  assign label_m1  = label_q - OW'(1);
  assign lab_m1    = lab_rdata - OW'(1);

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    sw_head_d   = sw_head_q;
    sw_run_d    = sw_run_q;
    sw_resp_d   = sw_resp_q;
    root_d      = root_q;
    cdepth_d    = cdepth_q;
    mdepth_d    = mdepth_q;
    ord_d       = ord_q;
    comp_d      = comp_q;
    label_d     = label_q;
    pcnt_d      = pcnt_q;
    total_d     = total_q;
    top_v_d     = top_v_q;
    top_e_d     = top_e_q;
    top_low_d   = top_low_q;
    top_vis_d   = top_vis_q;
    w_d         = w_q;
    u_d         = u_q;
    t_d         = t_q;
    tgt_we = 1'b0; lnk_we = 1'b0; head_we = 1'b0; vis_we = 1'b0; onk_we = 1'b0;
    lab_we = 1'b0; siz_we = 1'b0; mem_we = 1'b0; call_we = 1'b0;
    tgt_waddr  = total_q[EAW-1:0];
    tgt_wdata  = t_q;
    lnk_wdata  = head_rdata;
    edge_raddr = top_e_q[EAW-1:0];
    head_waddr = u_q;
    head_wdata = total_q;
    head_raddr = u_q;
    node_waddr = sweep_q[NW-1:0];
    node_raddr = root_q[NW-1:0];
    vis_wdata  = '0;
    onk_waddr  = sweep_q[NW-1:0];
    onk_wdata  = 1'b0;
    lab_waddr  = sweep_q[NW-1:0];
    lab_wdata  = '0;
    lab_raddr  = u_q;
    siz_waddr  = sweep_q[NW-1:0];
    siz_wdata  = '0;
    siz_raddr  = lab_m1[NW-1:0];
    mem_waddr  = mdepth_q[NW-1:0];
    mem_wdata  = '0;
    mem_raddr  = mdepth_m1[NW-1:0];
    call_waddr = cdepth_m1[NW-1:0];
    call_wdata = {top_v_q, top_e_q, top_low_q, top_vis_q};
    call_raddr = cdepth_m1[NW-1:0];
    do_enter    = 1'b0;
    enter_node  = w_q;
    enter_head  = head_rdata;
    resp        = 1'b0;
    resp_status = STAT_OK;
    resp_label  = '0;
    resp_size   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          u_d = from_m1[NW-1:0];
          t_d = to_m1[NW-1:0];
          unique case (cmd_i.action)
            ACT_ADD: begin
              if (from_bad || to_bad) begin
                resp        = 1'b1;
                resp_status = STAT_RANGE;
              end else if (total_q == EW'(MAX_EDGES)) begin
                resp        = 1'b1;
                resp_status = STAT_FULL;
              end else begin
                head_raddr = from_m1[NW-1:0];
                state_d    = ST_ADD_W;
              end
            end
            ACT_QUERY: begin
              if (from_bad) begin
                resp        = 1'b1;
                resp_status = STAT_RANGE;
              end else begin
                lab_raddr = from_m1[NW-1:0];
                state_d   = ST_QRY_W;
              end
            end
            ACT_RUN, ACT_CLEAR: begin
              sweep_d   = '0;
              sw_head_d = (cmd_i.action == ACT_CLEAR);
              sw_run_d  = (cmd_i.action == ACT_RUN);
              sw_resp_d = (cmd_i.action == ACT_CLEAR);
              root_d    = '0;
              cdepth_d  = '0;
              mdepth_d  = '0;
              ord_d     = '0;
              comp_d    = '0;
              if (cmd_i.action == ACT_CLEAR) begin
                total_d = '0;
              end
              state_d = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_W: begin
        tgt_we  = 1'b1;
        lnk_we  = 1'b1;
        head_we = 1'b1;
        total_d = total_q + EW'(1);
        resp    = 1'b1;
        state_d = ST_IDLE;
      end
      ST_QRY_W: begin
        label_d = lab_rdata;
        if (lab_rdata == '0) begin
          resp    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_QSZ_W;
        end
      end
      ST_QSZ_W: begin
        resp       = 1'b1;
        resp_label = label_q;
        resp_size  = siz_rdata;
        state_d    = ST_IDLE;
      end
      ST_SWEEP: begin
        vis_we     = 1'b1;
        onk_we     = 1'b1;
        lab_we     = 1'b1;
        siz_we     = 1'b1;
        head_we    = sw_head_q;
        head_waddr = sweep_q[NW-1:0];
        head_wdata = NULL_LINK;
        sweep_d    = sweep_q + OW'(1);
        if (sweep_q == OW'(MAX_NODES - 1)) begin
          if (sw_run_q) begin
            state_d = ST_ROOT;
          end else begin
            resp    = sw_resp_q;
            state_d = ST_IDLE;
          end
        end
      end
      ST_ROOT: begin
        if (root_q == active_n_i) begin
          resp    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          node_raddr = root_q[NW-1:0];
          head_raddr = root_q[NW-1:0];
          state_d    = ST_ROOT_W;
        end
      end
      ST_ROOT_W: begin
        if (vis_rdata != '0) begin
          root_d  = root_q + OW'(1);
          state_d = ST_ROOT;
        end else begin
          do_enter   = 1'b1;
          enter_node = root_q[NW-1:0];
          state_d    = ST_STEP;
        end
      end
      ST_STEP: begin
        if (top_e_q < total_q) begin
          state_d = ST_EDGE_W;
        end else begin
          cdepth_d = cdepth_m1;
          if (top_low_q == top_vis_q) begin
            comp_d  = comp_q + OW'(1);
            label_d = comp_q + OW'(1);
            pcnt_d  = '0;
            state_d = ST_POP;
          end else begin
            state_d = ST_PARENT;
          end
        end
      end
      ST_EDGE_W: begin
        top_e_d = lnk_rdata;
        if (32'(tgt_rdata) >= n32) begin
          state_d = ST_STEP;
        end else begin
          w_d        = tgt_rdata;
          node_raddr = tgt_rdata;
          head_raddr = tgt_rdata;
          state_d    = ST_VIS_W;
        end
      end
      ST_VIS_W: begin
        if (vis_rdata == '0) begin
          do_enter = 1'b1;
        end else if (onk_rdata && (vis_rdata < top_low_q)) begin
          top_low_d = vis_rdata;
        end
        state_d = ST_STEP;
      end
      ST_POP: begin
        if (mdepth_q == '0) begin
          siz_we    = 1'b1;
          siz_waddr = label_m1[NW-1:0];
          siz_wdata = pcnt_q;
          state_d   = ST_PARENT;
        end else begin
          state_d = ST_POP_W;
        end
      end
      ST_POP_W: begin
        lab_we    = 1'b1;
        lab_waddr = mem_rdata;
        lab_wdata = label_q;
        onk_we    = 1'b1;
        onk_waddr = mem_rdata;
        onk_wdata = 1'b0;
        mdepth_d  = mdepth_m1;
        pcnt_d    = pcnt_q + OW'(1);
        if (mem_rdata == top_v_q) begin
          siz_we    = 1'b1;
          siz_waddr = label_m1[NW-1:0];
          siz_wdata = pcnt_q + OW'(1);
          state_d   = ST_PARENT;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_PARENT: begin
        if (cdepth_q == '0) begin
          root_d  = root_q + OW'(1);
          state_d = ST_ROOT;
        end else begin
          state_d = ST_PAR_W;
        end
      end
      ST_PAR_W: begin
        {top_v_d, top_e_d, top_low_d, top_vis_d} = call_rdata;
        if (top_low_q < call_rdata[2*OW-1:OW]) begin
          top_low_d = top_low_q;
        end
        state_d = ST_STEP;
      end
      default: state_d = ST_IDLE;
    endcase

    // push a new frame; the current top (if any) moves into the call memory
    if (do_enter) begin
      call_we    = (cdepth_q != '0);
      vis_we     = 1'b1;
      node_waddr = enter_node;
      vis_wdata  = ord_p1;
      onk_we     = 1'b1;
      onk_waddr  = enter_node;
      onk_wdata  = 1'b1;
      mem_we     = 1'b1;
      mem_wdata  = enter_node;
      mdepth_d   = mdepth_q + OW'(1);
      cdepth_d   = cdepth_q + OW'(1);
      ord_d      = ord_p1;
      top_v_d    = enter_node;
      top_e_d    = enter_head;
      top_low_d  = ord_p1;
      top_vis_d  = ord_p1;
    end

    comp_ext = 32'(comp_d);
    lab_ext  = 32'(resp_label);
    siz_ext  = 32'(resp_size);
    res_valid_d           = resp;
    res_d.status          = resp_status;
    res_d.component_count = comp_ext[FIELD_W-1:0];
    res_d.node_label      = lab_ext[FIELD_W-1:0];
    res_d.label_size      = siz_ext[FIELD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      sw_head_q   <= 1'b1;
      sw_run_q    <= 1'b0;
      sw_resp_q   <= 1'b0;
      root_q      <= '0;
      cdepth_q    <= '0;
      mdepth_q    <= '0;
      ord_q       <= '0;
      comp_q      <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      sw_head_q   <= sw_head_d;
      sw_run_q    <= sw_run_d;
      sw_resp_q   <= sw_resp_d;
      root_q      <= root_d;
      cdepth_q    <= cdepth_d;
      mdepth_q    <= mdepth_d;
      ord_q       <= ord_d;
      comp_q      <= comp_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    label_q   <= label_d;
    pcnt_q    <= pcnt_d;
    top_v_q   <= top_v_d;
    top_e_q   <= top_e_d;
    top_low_q <= top_low_d;
    top_vis_q <= top_vis_d;
    w_q       <= w_d;
    u_q       <= u_d;
    t_q       <= t_d;
    res_q     <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_edge_target (
    .clk_i, .we_i(tgt_we), .waddr_i(tgt_waddr), .wdata_i(tgt_wdata),
    .raddr_i(edge_raddr), .rdata_o(tgt_rdata)
  );
  scc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_link (
    .clk_i, .we_i(lnk_we), .waddr_i(tgt_waddr), .wdata_i(lnk_wdata),
    .raddr_i(edge_raddr), .rdata_o(lnk_rdata)
  );
  scc_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_node_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );
  scc_ram #(.WIDTH(OW), .DEPTH(MAX_NODES)) u_visit_order (
    .clk_i, .we_i(vis_we), .waddr_i(node_waddr), .wdata_i(vis_wdata),
    .raddr_i(node_raddr), .rdata_o(vis_rdata)
  );
  scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_on_stack (
    .clk_i, .we_i(onk_we), .waddr_i(onk_waddr), .wdata_i(onk_wdata),
    .raddr_i(node_raddr), .rdata_o(onk_rdata)
  );
  scc_ram #(.WIDTH(OW), .DEPTH(MAX_NODES)) u_comp_label (
    .clk_i, .we_i(lab_we), .waddr_i(lab_waddr), .wdata_i(lab_wdata),
    .raddr_i(lab_raddr), .rdata_o(lab_rdata)
  );
  scc_ram #(.WIDTH(OW), .DEPTH(MAX_NODES)) u_comp_size (
    .clk_i, .we_i(siz_we), .waddr_i(siz_waddr), .wdata_i(siz_wdata),
    .raddr_i(siz_raddr), .rdata_o(siz_rdata)
  );
  scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_member_stack (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );
  // frames below the top: {node, next edge, low link, visit order}
  scc_ram #(.WIDTH(CFW), .DEPTH(MAX_NODES)) u_call_stack (
    .clk_i, .we_i(call_we), .waddr_i(call_waddr), .wdata_i(call_wdata),
    .raddr_i(call_raddr), .rdata_o(call_rdata)
  );

endmodule

[tb/sv/tb_strongly_connected_components_core.sv]
// Self-checking testbench for the strongly connected components core.
module tb_strongly_connected_components_core;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam int unsigned NODES     = 1024;
  localparam int unsigned EDGES     = 4096;
  localparam int unsigned NIL       = EDGES;
  localparam longint      MAX_CYCLE = 5_000_000;

  typedef struct {
    action_e    act;
    logic [10:0] src;
    logic [10:0] dst;
    int          gap;
    bit          drain;
  } cmd_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  action_i = 2'd0;
  logic [10:0] from_node_i = '0;
  logic [10:0] to_node_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [10:0] component_count_o;
  logic [10:0] node_label_o;
  logic [10:0] label_size_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  strongly_connected_components_core u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .from_node_i, .to_node_i,
    .done_o, .status_o, .component_count_o, .node_label_o, .label_size_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  // graph model state
  int unsigned edge_dst [EDGES];
  int unsigned edge_nxt [EDGES];
  int unsigned head     [NODES];
  int unsigned n_edges;
  int unsigned dfs_num  [NODES];
  int unsigned low      [NODES];
  bit          on_stk   [NODES];
  int unsigned label    [NODES];
  int unsigned size_of  [NODES];
  int unsigned mstack   [NODES];
  int unsigned mdepth;
  int unsigned cnode    [NODES];
  int unsigned cedge    [NODES];
  int unsigned cdepth;
  int unsigned order_cnt;
  int unsigned comp_cnt;
  int unsigned node_reg;

  cmd_item_t   pending_cmds[$];
  res_t        expected_res[$];
  cmd_item_t   cur;
  int          gap_cnt = 0;
  int          errors = 0;
  longint      cycles = 0;

  function automatic int unsigned active_n();
    return node_reg > NODES ? NODES : node_reg;
  endfunction

  function automatic void clear_search();
    for (int i = 0; i < NODES; i++) begin
      dfs_num[i] = 0; low[i] = 0; on_stk[i] = 0; label[i] = 0; size_of[i] = 0;
    end
    mdepth = 0; cdepth = 0; order_cnt = 0; comp_cnt = 0;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < NODES; i++) head[i] = NIL;
    n_edges = 0;
  endfunction

  function automatic void visit(int unsigned v);
    order_cnt++;
    dfs_num[v] = order_cnt;
    low[v] = order_cnt;
    on_stk[v] = 1;
    if (mdepth < NODES) begin
      mstack[mdepth] = v;
      mdepth++;
    end
    if (cdepth < NODES) begin
      cnode[cdepth] = v;
      cedge[cdepth] = head[v];
      cdepth++;
    end
  endfunction

  function automatic void tarjan();
    int unsigned n, v, e, w, m, u;
    n = active_n();
    clear_search();
    for (int unsigned r = 0; r < n; r++) begin
      if (dfs_num[r] != 0) continue;
      visit(r);
      while (cdepth > 0) begin
        v = cnode[cdepth-1];
        e = cedge[cdepth-1];
        if (e < EDGES && e < n_edges) begin
          w = edge_dst[e];
          cedge[cdepth-1] = edge_nxt[e];
          if (w < n) begin
            if (dfs_num[w] == 0) visit(w);
            else if (on_stk[w] && dfs_num[w] < low[v]) low[v] = dfs_num[w];
          end
        end else begin
          cdepth--;
          if (low[v] == dfs_num[v]) begin
            comp_cnt++;
            while (mdepth > 0) begin
              mdepth--;
              m = mstack[mdepth];
              label[m] = comp_cnt;
              if (comp_cnt - 1 < NODES) size_of[comp_cnt-1]++;
              on_stk[m] = 0;
              if (m == v) break;
            end
          end
          if (cdepth > 0) begin
            u = cnode[cdepth-1];
            if (low[v] < low[u]) low[u] = low[v];
          end
        end
      end
    end
  endfunction

  function automatic res_t predict_result(cmd_item_t c);
    res_t r;
    int unsigned n, f, t;
    n = active_n();
    f = 32'(c.src);
    t = 32'(c.dst);
    r = '0;
    r.status = STAT_OK;
    case (c.act)
      ACT_ADD: begin
        if (f == 0 || f > n || t == 0 || t > n) r.status = STAT_RANGE;
        else if (n_edges >= EDGES) r.status = STAT_FULL;
        else begin
          edge_dst[n_edges] = t - 1;
          edge_nxt[n_edges] = head[f-1];
          head[f-1] = n_edges;
          n_edges++;
        end
      end
      ACT_RUN: tarjan();
      ACT_QUERY: begin
        if (f == 0 || f > n) r.status = STAT_RANGE;
        else begin
          r.node_label = FIELD_W'(label[f-1]);
          if (label[f-1] != 0 && label[f-1] - 1 < NODES)
            r.label_size = FIELD_W'(size_of[label[f-1]-1]);
        end
      end
      default: begin
        clear_graph();
        clear_search();
      end
    endcase
    r.component_count = FIELD_W'(comp_cnt);
    return r;
  endfunction

  // command driver
  always @(posedge clk_i) begin
    logic nxt_start;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      nxt_start = start_i;
      if (start_i && !busy_o) begin
        expected_res.push_back(predict_result(cur));
        nxt_start = 1'b0;
        gap_cnt = pending_cmds.size() > 0 ? pending_cmds[0].gap : 0;
      end
      if (!nxt_start) begin
        if (gap_cnt > 0) gap_cnt--;
        else if (pending_cmds.size() > 0 &&
                 !(pending_cmds[0].drain && expected_res.size() > 0)) begin
          cur = pending_cmds.pop_front();
          action_i <= cur.act;
          from_node_i <= cur.src;
          to_node_i <= cur.dst;
          nxt_start = 1'b1;
        end
      end
      start_i <= nxt_start;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result beat st=%0d cc=%0d lbl=%0d sz=%0d", $time,
                 status_o, component_count_o, node_label_o, label_size_o);
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, status_o);
          errors++;
        end
        if (component_count_o !== want.component_count) begin
          $display("%0t: component_count exp %0d got %0d", $time,
                   want.component_count, component_count_o);
          errors++;
        end
        if (node_label_o !== want.node_label) begin
          $display("%0t: node_label exp %0d got %0d", $time, want.node_label, node_label_o);
          errors++;
        end
        if (label_size_o !== want.label_size) begin
          $display("%0t: label_size exp %0d got %0d", $time, want.label_size, label_size_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_cmd(action_e a, int f, int t, int gap = 0, bit drain = 0);
    cmd_item_t c;
    c.act = a; c.src = f[10:0]; c.dst = t[10:0]; c.gap = gap; c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || start_i || expected_res.size() > 0 || busy_o)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_node_count(int unsigned val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    node_reg = val & 32'h7FF;
  endtask

  function automatic int rand_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic random_phase(int unsigned count, int items, bit burst);
    int unsigned pick;
    int f, t;
    write_node_count(count);
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        f = $urandom_range(0, 2047);
        t = $urandom_range(0, 2047);
      end else begin
        f = $urandom_range(1, count > 0 ? (count > NODES ? NODES : count) : 1);
        t = $urandom_range(1, count > 0 ? (count > NODES ? NODES : count) : 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) push_cmd(ACT_ADD, f, t, rand_gap(burst));
      else if (pick < 63) push_cmd(ACT_RUN, f, t, rand_gap(burst));
      else if (pick < 97) push_cmd(ACT_QUERY, f, t, rand_gap(burst), pick == 96);
      else push_cmd(ACT_CLEAR, f, t, rand_gap(burst));
    end
    wait_idle();
  endtask

  initial begin
    clear_graph();
    clear_search();
    node_reg = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // single node, unlabelled query, self loop
    push_cmd(ACT_QUERY, 1, 0);
    push_cmd(ACT_QUERY, 0, 0, 3);
    push_cmd(ACT_ADD, 1, 1);
    push_cmd(ACT_ADD, 1, 2);
    push_cmd(ACT_RUN, 0, 0);
    push_cmd(ACT_QUERY, 1, 0);
    wait_idle();
    // empty node range
    write_node_count(0);
    push_cmd(ACT_RUN, 0, 0);
    push_cmd(ACT_ADD, 1, 1);
    wait_idle();
    write_node_count(5);
    push_cmd(ACT_ADD, 1, 2);
    push_cmd(ACT_ADD, 2, 3, 2);
    push_cmd(ACT_ADD, 3, 1);
    push_cmd(ACT_ADD, 4, 5);
    push_cmd(ACT_ADD, 0, 3);
    push_cmd(ACT_ADD, 2047, 1);
    push_cmd(ACT_RUN, 0, 0);
    push_cmd(ACT_QUERY, 2, 0);
    push_cmd(ACT_QUERY, 5, 0, 0, 1);
    wait_idle();
    // count lowered below loaded edges
    write_node_count(3);
    push_cmd(ACT_RUN, 0, 0);
    push_cmd(ACT_QUERY, 4, 0);
    push_cmd(ACT_QUERY, 3, 0);
    wait_idle();
    // above range clamps to the full node count
    write_node_count(2047);
    push_cmd(ACT_ADD, 1024, 1);
    push_cmd(ACT_ADD, 1, 1024);
    push_cmd(ACT_RUN, 0, 0);
    push_cmd(ACT_QUERY, 1024, 0);
    push_cmd(ACT_CLEAR, 0, 0);
    push_cmd(ACT_QUERY, 1, 0);
    wait_idle();

    // fill the edge store, then overflow it
    write_node_count(4);
    for (int i = 0; i < EDGES; i++)
      push_cmd(ACT_ADD, $urandom_range(1, 4), $urandom_range(1, 4));
    push_cmd(ACT_ADD, 2, 3);
    push_cmd(ACT_ADD, 9, 3);
    push_cmd(ACT_RUN, 0, 0);
    push_cmd(ACT_QUERY, 4, 0);
    push_cmd(ACT_CLEAR, 0, 0);
    wait_idle();

    random_phase(8, 110, 0);
    random_phase(3, 90, 1);
    random_phase(16, 120, 0);
    random_phase(1024, 80, 0);
    random_phase(1, 60, 0);
    random_phase(12, 120, 1);
    random_phase(0, 40, 0);
    random_phase(6, 120, 0);
    random_phase(2047, 60, 0);

    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
src/scc_pkg.sv
src/scc_ram.sv
src/scc_engine.sv
src/strongly_connected_components_core.sv
tb/sv/tb_strongly_connected_components_core.sv
